// ----- rtl/core/sha512_pkg.sv -----
// -----------------------------------------------------------------------------
// sha512_pkg
// Shared types, round constants and the rotate function for the SHA-512 engine.
// -----------------------------------------------------------------------------
package sha512_pkg;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic load_byte;  // shift data byte into the word assembly
    logic load_pad;   // shift a pad byte (0x80 or 0x00)
    logic pad_first;  // pad byte is 0x80
    logic load_len;   // push a length word
    logic len_high;   // which length word
    logic init_rnd;   // copy chain into working vars
    logic do_rnd;     // one compression round
    logic fold;       // add working vars into chain
    logic reset_msg;  // return to initial state
    logic count_byte; // bump the byte counter
  } sha512_cmd_t;

  typedef struct packed {
    logic       word_full;  // current byte completes a word
    logic       block_full; // that word completes the block
    logic [2:0] byte_pos;
    logic [3:0] word_cnt;
  } sha512_stat_t;

  localparam word_t IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam word_t RK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- rtl/core/sha512_hash_engine.sv -----
// -----------------------------------------------------------------------------
// sha512_hash_engine
// SHA-512 over a byte stream; eight digest words out per message.
// -----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | input     | valid / ready    | data_byte, has_byte, end_of_message
// out     | output    | out_valid/ready  | digest_word, word_index, last_word
//
// One byte per cycle while idle; a filled block adds a compression (80 rounds on
// one shared round unit, load and fold). End of message adds the padding bytes
// one per cycle plus one or two block compressions, then 8 output beats.
// Synchronous reset restores the initial hash value. Input stalls while busy.
module sha512_hash_engine #(
  parameter int BYTE_COUNT_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha512_pkg::*;

  sha512_cmd_t  cmd;
  sha512_stat_t stat;
  logic [6:0]   rnd;
  logic [2:0]   out_sel;

  sha512_ctrl u_ctrl (
    .clk, .rst, .in_valid(valid), .in_ready(ready), .has_byte, .end_of_message,
    .stat, .cmd, .rnd, .out_sel, .out_valid, .out_ready);

  sha512_datapath #(.BYTE_COUNT_WIDTH(BYTE_COUNT_WIDTH)) u_dp (
    .clk, .rst, .cmd, .data_byte, .rnd, .out_sel, .stat, .chain_word(digest_word));

  assign word_index = out_sel;
  assign last_word  = (out_sel == 3'd7);

endmodule

// ----- rtl/core/sha512_datapath.sv -----
// -----------------------------------------------------------------------------
// sha512_datapath
// Word assembly, 16-word schedule window, round registers, chain and count.
// -----------------------------------------------------------------------------
module sha512_datapath #(
  parameter int BYTE_COUNT_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sha512_pkg::sha512_cmd_t  cmd,
  input  logic [7:0]               data_byte,
  input  logic [6:0]               rnd,
  input  logic [2:0]               out_sel,
  output sha512_pkg::sha512_stat_t stat,
  output sha512_pkg::word_t        chain_word
);
  import sha512_pkg::*;

  word_t w [16];
  word_t chain [8];
  word_t a, b, c, d, e, f, g, h;
  word_t assembly;
  logic [2:0] byte_pos;
  logic [3:0] word_cnt;
  logic [BYTE_COUNT_WIDTH-1:0] msg_bytes;
  logic [127:0] len_bits;
  logic [7:0] in_byte;
  word_t assembly_next, push_word, s0, s1, w_new, t1, t2;
  logic push;

  assign in_byte = cmd.load_byte ? data_byte : (cmd.pad_first ? 8'h80 : 8'h00);
  assign assembly_next = {assembly[55:0], in_byte};
  assign len_bits = {{(128-BYTE_COUNT_WIDTH){1'b0}}, msg_bytes} << 3;
  assign push_word = cmd.load_len ? (cmd.len_high ? len_bits[127:64] : len_bits[63:0])
                                  : assembly_next;
  assign push = cmd.load_len || ((cmd.load_byte || cmd.load_pad) && byte_pos == 3'd7);

  assign stat.word_full  = (byte_pos == 3'd7);
  assign stat.block_full = (word_cnt == 4'd15);
  assign stat.byte_pos   = byte_pos;
  assign stat.word_cnt   = word_cnt;

  assign s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
  assign s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
  assign w_new = s1 + w[9] + s0 + w[0];
  assign t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
              + RK[rnd] + w[0];
  assign t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
  assign chain_word = chain[out_sel];

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_msg) begin
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
      for (int i = 0; i < 16; i++) w[i] <= '0;
      assembly <= '0;
      byte_pos <= '0;
      word_cnt <= '0;
      msg_bytes <= '0;
    end else begin
      if (cmd.count_byte && msg_bytes != '1) msg_bytes <= msg_bytes + 1'b1;
      if (cmd.load_byte || cmd.load_pad) begin
        byte_pos <= byte_pos + 3'd1;
        assembly <= (byte_pos == 3'd7) ? '0 : assembly_next;
      end
      if (push) begin
        w[word_cnt] <= push_word;
        word_cnt <= word_cnt + 4'd1;
      end
      if (cmd.do_rnd) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w_new;
      end
      if (cmd.fold) begin
        chain[0] <= chain[0] + a; chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c; chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e; chain[5] <= chain[5] + f;
        chain[6] <= chain[6] + g; chain[7] <= chain[7] + h;
        for (int i = 0; i < 16; i++) w[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_rnd) begin
      a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
      e <= chain[4]; f <= chain[5]; g <= chain[6]; h <= chain[7];
    end else if (cmd.do_rnd) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

endmodule

// ----- rtl/core/sha512_ctrl.sv -----
// -----------------------------------------------------------------------------
// sha512_ctrl
// Sequencer: byte intake, padding, round counting and digest readout.
// -----------------------------------------------------------------------------
module sha512_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     has_byte,
  input  logic                     end_of_message,
  input  sha512_pkg::sha512_stat_t stat,
  output sha512_pkg::sha512_cmd_t  cmd,
  output logic [6:0]               rnd,
  output logic [2:0]               out_sel,
  output logic                     out_valid,
  input  logic                     out_ready
);
  import sha512_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic finishing, first_pad, len_phase;
  logic in_fire;
  logic blk_push;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    blk_push = 1'b0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.load_byte  = has_byte;
        cmd.count_byte = has_byte;
        blk_push = has_byte && stat.word_full && stat.block_full;
        if (blk_push) state_next = S_INIT;
        else if (end_of_message) state_next = S_PAD;
      end
      S_PAD: begin
        if (len_phase) begin
          cmd.load_len = 1'b1;
          cmd.len_high = (stat.word_cnt == 4'd14);
          if (stat.word_cnt == 4'd15) state_next = S_INIT;
        end else if (!first_pad && stat.byte_pos == 3'd0 && stat.word_cnt == 4'd14) begin
          cmd.load_len = 1'b1;
          cmd.len_high = 1'b1;
        end else begin
          cmd.load_pad  = 1'b1;
          cmd.pad_first = first_pad;
          if (stat.word_full && stat.block_full) state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_rnd = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.do_rnd = 1'b1;
        if (rnd == 7'd79) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        state_next = finishing ? (len_phase ? S_OUT : S_PAD) : S_IDLE;
      end
      S_OUT: if (out_ready && out_sel == 3'd7) begin
        cmd.reset_msg = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      finishing <= 1'b0;
      first_pad <= 1'b0;
      len_phase <= 1'b0;
      rnd <= '0;
      out_sel <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_fire) begin
        finishing <= end_of_message;
        first_pad <= 1'b1;
        len_phase <= 1'b0;
      end
      if (cmd.load_pad) first_pad <= 1'b0;
      if (cmd.load_len && cmd.len_high) len_phase <= 1'b1;
      if (state == S_INIT) rnd <= '0;
      else if (cmd.do_rnd) rnd <= rnd + 7'd1;
      // index wraps to zero on the eighth beat
      if (state == S_OUT && out_ready) out_sel <= out_sel + 3'd1;
      if (cmd.reset_msg) begin
        finishing <= 1'b0;
        len_phase <= 1'b0;
      end
    end
  end

  ap_rnd_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> rnd <= 7'd79) else $error("round counter overrun");
  ap_out_sel_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> out_sel == 3'd0) else $error("readout index not cleared");
  ap_fold_after_round: assert property (@(posedge clk) disable iff (rst)
    state == S_FOLD |-> $past(state) == S_ROUND) else $error("fold without rounds");

endmodule
